// ----- rtl/jtm_pkg.sv -----
package jtm_pkg;

  // Default sizes of the scan word and of the run-test pulse count.
  localparam int WORD_BITS_DEF     = 32;
  localparam int MAX_RUN_TICKS_DEF = 32;

  // Pulses with TMS high that walk the TAP into Test-Logic-Reset.
  localparam int RESET_HIGH_PULSES = 8;

  // Fixed widths of the item fields.
  localparam int FIELD_BITS  = 32;
  localparam int OP_W        = 2;
  localparam int COUNT_FLD_W = 6;

  // Command codes.
  localparam logic [OP_W-1:0] OP_RESET    = 2'd0;
  localparam logic [OP_W-1:0] OP_DR_SCAN  = 2'd1;
  localparam logic [OP_W-1:0] OP_IR_SCAN  = 2'd2;
  localparam logic [OP_W-1:0] OP_RUN_IDLE = 2'd3;

  // Microcode addresses.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_RESET_HIGH  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RESET_IDLE  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_IR_SELECT   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DR_SELECT   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CAPTURE     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SHIFT_ENTRY = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SHIFT       = 4'd6;
  localparam logic [STEP_W-1:0] STEP_UPDATE      = 4'd7;
  localparam logic [STEP_W-1:0] STEP_IDLE        = 4'd8;
  localparam logic [STEP_W-1:0] STEP_RUN         = 4'd9;

  // One control word per microcode step.
  typedef struct packed {
    logic tms;          // TMS level of the pulse
    logic tms_at_end;   // TMS high on the final pass of a repeated step
    logic repeat_step;  // stay on this step until the pulse counter runs out
    logic shift;        // shift one data bit out and one captured bit in
    logic clear_held;   // force the data-out level low
    logic last;         // final pulse of the command
    logic last_at_end;  // final pulse when the pulse counter runs out
    logic show_cap;     // present the captured word on this pulse
    logic done;         // the program ends after this step
  } ctrl_word_t;

  // What the sequencer hands the datapath for one pulse.
  typedef struct packed {
    ctrl_word_t word;
    logic       count_end;
  } pulse_ctrl_t;

  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '0;
    case (step)
      STEP_RESET_HIGH: begin
        w.tms         = 1'b1;
        w.repeat_step = 1'b1;
        w.clear_held  = 1'b1;
      end
      STEP_RESET_IDLE: begin
        w.last = 1'b1;
        w.done = 1'b1;
      end
      STEP_IR_SELECT: begin
        w.tms = 1'b1;
      end
      STEP_DR_SELECT: begin
        w.tms = 1'b1;
      end
      STEP_CAPTURE: begin
        w.tms = 1'b0;
      end
      STEP_SHIFT_ENTRY: begin
        w.tms = 1'b0;
      end
      STEP_SHIFT: begin
        w.tms_at_end  = 1'b1;
        w.repeat_step = 1'b1;
        w.shift       = 1'b1;
      end
      STEP_UPDATE: begin
        w.tms = 1'b1;
      end
      STEP_IDLE: begin
        w.last     = 1'b1;
        w.show_cap = 1'b1;
        w.done     = 1'b1;
      end
      STEP_RUN: begin
        w.repeat_step = 1'b1;
        w.last_at_end = 1'b1;
        w.done        = 1'b1;
      end
      default: begin
        w.last = 1'b1;
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] entry_step(input logic [OP_W-1:0] op);
    logic [STEP_W-1:0] s;
    case (op)
      OP_RESET:    s = STEP_RESET_HIGH;
      OP_DR_SCAN:  s = STEP_DR_SELECT;
      OP_IR_SCAN:  s = STEP_IR_SELECT;
      OP_RUN_IDLE: s = STEP_RUN;
      default:     s = STEP_RESET_HIGH;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/jtag_tap_scan_master_unit.sv -----
// Channel   Direction  Handshake            Item contents
// input     in         in_valid/in_stall    op, shift_data, bit_count, tick_count, target_bits
// output    out        out_valid/out_stall  tms_level, data_out_level, last_pulse, captured_word
//
// A command yields 9 TCK pulses for reset, 5 + n for a DR scan and 6 + n for an IR scan
// (n is bit_count, zero taken as 1 and capped at WORD_BITS), and tick_count capped at
// MAX_RUN_TICKS for run-test, where zero ends at once.
// The microcode sequencer issues one step per cycle. A stalled output holds it on its step,
// and the next command is taken once the last pulse of the previous one has been issued.
// Reset is synchronous and clears the sequencer, the output valid and the held data-out level.
module jtag_tap_scan_master_unit #(
  parameter int WORD_BITS     = jtm_pkg::WORD_BITS_DEF,
  parameter int MAX_RUN_TICKS = jtm_pkg::MAX_RUN_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [jtm_pkg::OP_W-1:0]        op,
  input  logic [jtm_pkg::FIELD_BITS-1:0]  shift_data,
  input  logic [jtm_pkg::COUNT_FLD_W-1:0] bit_count,
  input  logic [jtm_pkg::COUNT_FLD_W-1:0] tick_count,
  input  logic [jtm_pkg::FIELD_BITS-1:0]  target_bits,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            tms_level,
  output logic                            data_out_level,
  output logic                            last_pulse,
  output logic [jtm_pkg::FIELD_BITS-1:0]  captured_word
);

  logic                 busy;
  logic                 start;
  logic                 fire;
  jtm_pkg::pulse_ctrl_t pulse;
  logic                 pulse_last;

  // The block is busy for the whole of one command.
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  // A pulse is issued whenever the output register is free or being emptied.
  assign fire = busy && (!out_valid || !out_stall);

  assign pulse_last = pulse.word.last | (pulse.word.last_at_end & pulse.count_end);

  jtm_sequencer #(
    .WORD_BITS     (WORD_BITS),
    .MAX_RUN_TICKS (MAX_RUN_TICKS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .bit_count  (bit_count),
    .tick_count (tick_count),
    .fire       (fire),
    .busy       (busy),
    .pulse      (pulse)
  );

  jtm_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .load           (start),
    .shift_data     (shift_data),
    .target_bits    (target_bits),
    .fire           (fire),
    .pulse          (pulse),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .tms_level      (tms_level),
    .data_out_level (data_out_level),
    .last_pulse     (last_pulse),
    .captured_word  (captured_word)
  );

  // Issuing the final pulse of a command ends the program.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    fire && pulse_last |=> !busy)
    else $error("sequencer still busy after the final pulse");

  // Any other pulse leaves the program running.
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    fire && !pulse_last |=> busy)
    else $error("sequencer stopped before the final pulse");

  // A captured word is only ever shown on the final pulse.
  a_cap_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (captured_word != '0) |-> last_pulse)
    else $error("captured word shown on a pulse that is not the last");

endmodule

// ----- rtl/jtm_sequencer.sv -----
module jtm_sequencer #(
  parameter int WORD_BITS     = jtm_pkg::WORD_BITS_DEF,
  parameter int MAX_RUN_TICKS = jtm_pkg::MAX_RUN_TICKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [jtm_pkg::OP_W-1:0]       op,
  input  logic [jtm_pkg::COUNT_FLD_W-1:0] bit_count,
  input  logic [jtm_pkg::COUNT_FLD_W-1:0] tick_count,
  input  logic                           fire,
  output logic                           busy,
  output jtm_pkg::pulse_ctrl_t           pulse
);

  localparam int MAX_A   = (WORD_BITS > MAX_RUN_TICKS) ? WORD_BITS : MAX_RUN_TICKS;
  localparam int CNT_MAX = (MAX_A > jtm_pkg::RESET_HIGH_PULSES) ? MAX_A
                                                              : jtm_pkg::RESET_HIGH_PULSES;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int SAT_W   = (CNT_W > jtm_pkg::COUNT_FLD_W) ? CNT_W : jtm_pkg::COUNT_FLD_W;

  logic [jtm_pkg::STEP_W-1:0] step;
  logic [CNT_W-1:0]           cnt;
  logic [SAT_W-1:0]           scan_len;
  logic [SAT_W-1:0]           run_len;
  logic [SAT_W-1:0]           load_len;
  logic                       empty;
  jtm_pkg::ctrl_word_t        word;
  logic                       count_end;

  // Clamp the requested lengths to what the datapath supports.
  always_comb begin
    scan_len = SAT_W'(bit_count);
    if (scan_len == '0) begin
      scan_len = SAT_W'(1);
    end
    if (scan_len > SAT_W'(WORD_BITS)) begin
      scan_len = SAT_W'(WORD_BITS);
    end
    run_len = SAT_W'(tick_count);
    if (run_len > SAT_W'(MAX_RUN_TICKS)) begin
      run_len = SAT_W'(MAX_RUN_TICKS);
    end
    case (op)
      jtm_pkg::OP_RESET:    load_len = SAT_W'(jtm_pkg::RESET_HIGH_PULSES);
      jtm_pkg::OP_RUN_IDLE: load_len = run_len;
      default:              load_len = scan_len;
    endcase
    empty = (op == jtm_pkg::OP_RUN_IDLE) && (run_len == '0);
  end

  assign word            = jtm_pkg::ucode(step);
  assign count_end       = (cnt == CNT_W'(1));
  assign pulse.word      = word;
  assign pulse.count_end = count_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= jtm_pkg::STEP_RESET_HIGH;
      cnt  <= '0;
    end else if (start) begin
      // A run-test command with no pulses produces nothing at all.
      busy <= !empty;
      step <= jtm_pkg::entry_step(op);
      cnt  <= load_len[CNT_W-1:0];
    end else if (fire) begin
      if (word.repeat_step && !count_end) begin
        cnt <= cnt - CNT_W'(1);
      end else if (word.done) begin
        busy <= 1'b0;
      end else begin
        step <= step + jtm_pkg::STEP_W'(1);
      end
    end
  end

endmodule

// ----- rtl/jtm_datapath.sv -----
module jtm_datapath #(
  parameter int WORD_BITS = jtm_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [jtm_pkg::FIELD_BITS-1:0]  shift_data,
  input  logic [jtm_pkg::FIELD_BITS-1:0]  target_bits,
  input  logic                            fire,
  input  jtm_pkg::pulse_ctrl_t            pulse,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            tms_level,
  output logic                            data_out_level,
  output logic                            last_pulse,
  output logic [jtm_pkg::FIELD_BITS-1:0]  captured_word
);

  localparam int EXT_W = WORD_BITS + jtm_pkg::FIELD_BITS;

  logic [WORD_BITS-1:0]            sreg;
  logic [WORD_BITS-1:0]            cap;
  logic [jtm_pkg::FIELD_BITS-1:0]  tbits;
  logic                            held;
  logic                            held_next;
  logic [EXT_W-1:0]                data_ext;
  logic [EXT_W-1:0]                cap_ext;
  logic                            tms_next;
  logic                            last_next;

  assign data_ext = {{WORD_BITS{1'b0}}, shift_data};
  assign cap_ext  = {{jtm_pkg::FIELD_BITS{1'b0}}, cap};

  always_comb begin
    if (pulse.word.clear_held) begin
      held_next = 1'b0;
    end else if (pulse.word.shift) begin
      held_next = sreg[WORD_BITS-1];
    end else begin
      held_next = held;
    end
    tms_next  = pulse.word.tms | (pulse.word.tms_at_end & pulse.count_end);
    last_next = pulse.word.last | (pulse.word.last_at_end & pulse.count_end);
  end

  // Scan registers: the target's bits enter at the top of the captured word.
  always_ff @(posedge clk) begin
    if (load) begin
      sreg  <= data_ext[WORD_BITS-1:0];
      cap   <= '0;
      tbits <= target_bits;
    end else if (fire && pulse.word.shift) begin
      sreg  <= {sreg[WORD_BITS-2:0], 1'b0};
      cap   <= {tbits[0], cap[WORD_BITS-1:1]};
      tbits <= {1'b0, tbits[jtm_pkg::FIELD_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (fire) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tms_level      <= tms_next;
      data_out_level <= held_next;
      last_pulse     <= last_next;
      captured_word  <= pulse.word.show_cap ? cap_ext[jtm_pkg::FIELD_BITS-1:0] : '0;
    end
  end

endmodule

// ----- test/jtag_tap_scan_master_unit_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the JTAG master, predicts the TCK pulses of every
// accepted command and compares each delivered pulse with the oldest one due.
module jtag_pulse_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [jtm_pkg::OP_W-1:0]        op,
  input  logic [jtm_pkg::FIELD_BITS-1:0]  shift_data,
  input  logic [jtm_pkg::COUNT_FLD_W-1:0] bit_count,
  input  logic [jtm_pkg::COUNT_FLD_W-1:0] tick_count,
  input  logic [jtm_pkg::FIELD_BITS-1:0]  target_bits,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            tms_level,
  input  logic                            data_out_level,
  input  logic                            last_pulse,
  input  logic [jtm_pkg::FIELD_BITS-1:0]  captured_word,
  output int                              fail_count,
  output int                              pending
);

  localparam int SCAN_BITS = jtm_pkg::WORD_BITS_DEF;
  localparam int RUN_LIMIT = jtm_pkg::MAX_RUN_TICKS_DEF;

  typedef struct {
    logic                           tms;
    logic                           tdi;
    logic                           last;
    logic [jtm_pkg::FIELD_BITS-1:0] cap;
  } tck_pulse_t;

  tck_pulse_t expected_pulses[$];
  logic       held_tdi;
  int         pulse_index;

  initial begin
    fail_count  = 0;
    pending     = 0;
    held_tdi    = 1'b0;
    pulse_index = 0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: pulse %0d: %s", $realtime, pulse_index, what);
    fail_count = fail_count + 1;
  endtask

  task automatic queue_pulse(input logic tms, input logic last,
                             input logic [jtm_pkg::FIELD_BITS-1:0] cap);
    tck_pulse_t p;
    p.tms  = tms;
    p.tdi  = held_tdi;
    p.last = last;
    p.cap  = cap;
    expected_pulses.push_back(p);
  endtask

  // Expands one command into the pulses it must produce.
  task automatic predict_pulses(input logic [jtm_pkg::OP_W-1:0] cmd,
                                input logic [jtm_pkg::FIELD_BITS-1:0] data,
                                input logic [jtm_pkg::COUNT_FLD_W-1:0] nbits_in,
                                input logic [jtm_pkg::COUNT_FLD_W-1:0] ticks_in,
                                input logic [jtm_pkg::FIELD_BITS-1:0] tdo);
    int                             nbits;
    int                             ticks;
    logic [jtm_pkg::FIELD_BITS-1:0] sdata;
    logic [jtm_pkg::FIELD_BITS-1:0] cap;
    sdata = data;
    cap   = '0;
    case (cmd)
      jtm_pkg::OP_RESET: begin
        held_tdi = 1'b0;
        repeat (jtm_pkg::RESET_HIGH_PULSES) queue_pulse(1'b1, 1'b0, '0);
        queue_pulse(1'b0, 1'b1, '0);
      end
      jtm_pkg::OP_RUN_IDLE: begin
        ticks = (ticks_in > RUN_LIMIT) ? RUN_LIMIT : int'(ticks_in);
        for (int i = 0; i < ticks; i++) queue_pulse(1'b0, i == ticks - 1, '0);
      end
      default: begin
        nbits = (nbits_in == 0) ? 1 : int'(nbits_in);
        if (nbits > SCAN_BITS) nbits = SCAN_BITS;
        if (cmd == jtm_pkg::OP_IR_SCAN) queue_pulse(1'b1, 1'b0, '0);
        queue_pulse(1'b1, 1'b0, '0);
        queue_pulse(1'b0, 1'b0, '0);
        queue_pulse(1'b0, 1'b0, '0);
        for (int i = 0; i < nbits; i++) begin
          held_tdi = sdata[SCAN_BITS-1];
          sdata    = sdata << 1;
          queue_pulse(i == nbits - 1, 1'b0, '0);
          cap = cap >> 1;
          if (tdo[i]) cap[SCAN_BITS-1] = 1'b1;
        end
        queue_pulse(1'b1, 1'b0, '0);
        queue_pulse(1'b0, 1'b1, cap);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    tck_pulse_t want;
    if (rst) begin
      held_tdi = 1'b0;
      expected_pulses.delete();
    end else begin
      // A pulse can never belong to a command accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_pulses.size() == 0) begin
          report_mismatch("pulse delivered with none due");
        end else begin
          want = expected_pulses.pop_front();
          if (tms_level !== want.tms)
            report_mismatch($sformatf("tms %b, want %b", tms_level, want.tms));
          if (data_out_level !== want.tdi)
            report_mismatch($sformatf("tdi %b, want %b", data_out_level, want.tdi));
          if (last_pulse !== want.last)
            report_mismatch($sformatf("last %b, want %b", last_pulse, want.last));
          if (captured_word !== want.cap)
            report_mismatch($sformatf("captured %h, want %h", captured_word, want.cap));
        end
        pulse_index = pulse_index + 1;
      end
      if (in_valid && !in_stall)
        predict_pulses(op, shift_data, bit_count, tick_count, target_bits);
    end
    pending <= expected_pulses.size();
  end

endmodule

// ----- test/jtag_tap_scan_master_unit_test.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the JTAG scan master. The checker beside the block
// does all prediction and comparison; this module only makes commands, drives
// the output stall and decides pass or fail.
module jtag_tap_scan_master_unit_test;

  // Cycles with no item moving on either channel before the run is abandoned.
  // Every pulse and every accepted command restarts the count, so a correct run never
  // comes near the limit, even with the receiver stalling about two times in three.
  localparam int STALL_LIMIT = 2000;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [jtm_pkg::OP_W-1:0]        op;
  logic [jtm_pkg::FIELD_BITS-1:0]  shift_data;
  logic [jtm_pkg::COUNT_FLD_W-1:0] bit_count;
  logic [jtm_pkg::COUNT_FLD_W-1:0] tick_count;
  logic [jtm_pkg::FIELD_BITS-1:0]  target_bits;
  logic                            out_valid;
  logic                            out_stall;
  logic                            tms_level;
  logic                            data_out_level;
  logic                            last_pulse;
  logic [jtm_pkg::FIELD_BITS-1:0]  captured_word;

  int fail_count;
  int pending;
  int send_gap_pct;
  int stall_pct;
  int quiet_cycles;

  always #2 clk = ~clk;

  jtag_tap_scan_master_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .shift_data     (shift_data),
    .bit_count      (bit_count),
    .tick_count     (tick_count),
    .target_bits    (target_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tms_level      (tms_level),
    .data_out_level (data_out_level),
    .last_pulse     (last_pulse),
    .captured_word  (captured_word)
  );

  jtag_pulse_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .shift_data     (shift_data),
    .bit_count      (bit_count),
    .tick_count     (tick_count),
    .target_bits    (target_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tms_level      (tms_level),
    .data_out_level (data_out_level),
    .last_pulse     (last_pulse),
    .captured_word  (captured_word),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // The receiver stalls at random, at the rate the current phase sets.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // The watchdog restarts whenever an item moves on either channel. A block
  // that hangs, or a pulse that never comes, ends the run here.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one command and returns at the edge where it is accepted. The
  // sender may idle at random first; valid stays high across
  // back-to-back items and the payload holds while the block stalls.
  task automatic send_cmd(input logic [jtm_pkg::OP_W-1:0] c,
                          input logic [jtm_pkg::FIELD_BITS-1:0] d,
                          input int nb, input int tk,
                          input logic [jtm_pkg::FIELD_BITS-1:0] tb);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= c;
    shift_data  <= d;
    bit_count   <= nb[jtm_pkg::COUNT_FLD_W-1:0];
    tick_count  <= tk[jtm_pkg::COUNT_FLD_W-1:0];
    target_bits <= tb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender back until every predicted pulse has been delivered.
  // The first edge lets the checker count the command accepted last.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed scans with random content. Lengths stay within the
  // word as a rule, but zero and oversize counts turn up now and then so the
  // clamping paths get exercised as well.
  task automatic send_random_cmd();
    int pick;
    int nb;
    int tk;
    pick = $urandom_range(99);
    nb   = ($urandom_range(99) < 85) ? $urandom_range(1, 32) : $urandom_range(0, 63);
    tk   = ($urandom_range(99) < 80) ? $urandom_range(0, 32) : $urandom_range(0, 63);
    if (pick < 8)
      send_cmd(jtm_pkg::OP_RESET, $urandom, nb, tk, $urandom);
    else if (pick < 48)
      send_cmd(jtm_pkg::OP_DR_SCAN, $urandom, nb, tk, $urandom);
    else if (pick < 83)
      send_cmd(jtm_pkg::OP_IR_SCAN, $urandom, nb, tk, $urandom);
    else
      send_cmd(jtm_pkg::OP_RUN_IDLE, $urandom, nb, tk, $urandom);
  endtask

  task automatic run_random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      send_random_cmd();
      // Halfway through, let the block run dry before going on.
      if (i == count / 2) wait_for_drain();
    end
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    op           <= jtm_pkg::OP_RESET;
    shift_data   <= '0;
    bit_count    <= '0;
    tick_count   <= '0;
    target_bits  <= '0;
    out_stall    <= 1'b0;
    quiet_cycles <= 0;
    send_gap_pct = 7;
    stall_pct    = 66;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed commands. The first reset walks the TAP to Run-Test/Idle
    // from an unknown state.
    send_cmd(jtm_pkg::OP_RESET, '0, 0, 0, '0);
    // One-bit and full-word DR scans with all-ones, all-zeros and alternating patterns.
    send_cmd(jtm_pkg::OP_DR_SCAN, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF);
    send_cmd(jtm_pkg::OP_DR_SCAN, 32'hFFFF_FFFF, 32, 0, 32'hFFFF_FFFF);
    send_cmd(jtm_pkg::OP_DR_SCAN, 32'h0000_0000, 32, 0, 32'h0000_0000);
    send_cmd(jtm_pkg::OP_DR_SCAN, 32'hA5A5_5A5A, 32, 63, 32'h5A5A_A5A5);
    // A zero length shifts one bit; lengths past the word are clamped to it.
    send_cmd(jtm_pkg::OP_DR_SCAN, 32'h8000_0000, 0, 0, 32'h0000_0001);
    send_cmd(jtm_pkg::OP_DR_SCAN, 32'h1234_5678, 33, 0, 32'h8765_4321);
    send_cmd(jtm_pkg::OP_DR_SCAN, 32'hDEAD_BEEF, 63, 0, 32'hCAFE_F00D);
    // IR scans of the same extremes.
    send_cmd(jtm_pkg::OP_IR_SCAN, 32'h8000_0000, 1, 0, 32'h0000_0001);
    send_cmd(jtm_pkg::OP_IR_SCAN, 32'h5555_5555, 32, 0, 32'hAAAA_AAAA);
    send_cmd(jtm_pkg::OP_IR_SCAN, 32'hAAAA_AAAA, 0, 0, 32'h5555_5555);
    send_cmd(jtm_pkg::OP_IR_SCAN, 32'hF0F0_0F0F, 40, 0, 32'h0F0F_F0F0);
    // The last scan left the data-out line high; idle pulses must show it.
    send_cmd(jtm_pkg::OP_DR_SCAN, 32'h8000_0000, 1, 0, 32'h0);
    send_cmd(jtm_pkg::OP_RUN_IDLE, '0, 0, 1, '0);
    // A run-test of zero pulses produces nothing at all.
    send_cmd(jtm_pkg::OP_RUN_IDLE, '0, 0, 0, '0);
    send_cmd(jtm_pkg::OP_RUN_IDLE, '0, 0, 32, '0);
    send_cmd(jtm_pkg::OP_RUN_IDLE, '0, 0, 33, '0);
    send_cmd(jtm_pkg::OP_RUN_IDLE, '0, 0, 63, '0);
    // Reset drives the data-out line low from its first pulse on.
    send_cmd(jtm_pkg::OP_IR_SCAN, 32'hFFFF_FFFF, 8, 0, 32'h0);
    send_cmd(jtm_pkg::OP_RESET, 32'hFFFF_FFFF, 63, 63, 32'hFFFF_FFFF);
    send_cmd(jtm_pkg::OP_RUN_IDLE, '0, 0, 2, '0);
    // Zero-length run-tests back to back with scans.
    send_cmd(jtm_pkg::OP_RUN_IDLE, '0, 0, 0, '0);
    send_cmd(jtm_pkg::OP_DR_SCAN, 32'h4000_0000, 2, 0, 32'h0000_0002);
    send_cmd(jtm_pkg::OP_RUN_IDLE, '0, 0, 0, '0);
    wait_for_drain();

    // Random commands: sender rarely idles while the receiver stalls a lot.
    run_random_phase(32);
    wait_for_drain();

    // Then the other way round.
    send_gap_pct = 66;
    stall_pct    = 7;
    run_random_phase(32);
    wait_for_drain();

    // Finally full throughput on both sides.
    send_gap_pct = 0;
    stall_pct    = 0;
    run_random_phase(32);
    wait_for_drain();

    // Give any stray pulse time to show up before the verdict.
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
